// File: hw/rtl/atms_pkg.sv
// Types, codes and match patterns for the AT modem session sequencer.
`timescale 1ns / 1ps

package atms_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RETRY_DELAY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CMD_TIMEOUT = 2'd1;

  localparam logic [TIME_W-1:0] RETRY_DELAY_RESET = 32'd5000;
  localparam logic [TIME_W-1:0] CMD_TIMEOUT_RESET = 32'd10000;

  // Operations.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Session phases: command phases 0..7, then online and retry wait.
  localparam logic [3:0] PH_SYNC     = 4'd0;
  localparam logic [3:0] PH_ANNOUNCE = 4'd7;
  localparam logic [3:0] PH_ONLINE   = 4'd8;
  localparam logic [3:0] PH_RETRY    = 4'd9;

  // Notices.
  localparam logic [2:0] NOTICE_NONE     = 3'd0;
  localparam logic [2:0] NOTICE_ERROR    = 3'd1;
  localparam logic [2:0] NOTICE_TIMEOUT  = 3'd2;
  localparam logic [2:0] NOTICE_TOO_LONG = 3'd3;
  localparam logic [2:0] NOTICE_ONLINE   = 3'd4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [3:0] PREFIX_LEN = 4'd13;
  localparam logic [3:0] DISC_LEN   = 4'd12;
  localparam logic [2:0] ERROR_LEN  = 3'd5;
  localparam logic [1:0] OK_LEN     = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [7:0]        rx_byte;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       send_command;
    logic [2:0] command_code;
    logic       rpc_line;
    logic [3:0] session_state;
    logic [2:0] notice;
  } out_item_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "+";
      4'd1:    c = "M";
      4'd2:    c = "Q";
      4'd3:    c = "T";
      4'd4:    c = "T";
      4'd5:    c = "S";
      4'd6:    c = "U";
      4'd7:    c = "B";
      4'd8:    c = "R";
      4'd9:    c = "E";
      4'd10:   c = "C";
      4'd11:   c = "V";
      4'd12:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] disc_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "D";
      4'd1:    c = "I";
      4'd2:    c = "S";
      4'd3:    c = "C";
      4'd4:    c = "O";
      4'd5:    c = "N";
      4'd6:    c = "N";
      4'd7:    c = "E";
      4'd8:    c = "C";
      4'd9:    c = "T";
      4'd10:   c = "E";
      4'd11:   c = "D";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] error_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "E";
      3'd1:    c = "R";
      3'd2:    c = "R";
      3'd3:    c = "O";
      3'd4:    c = "R";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ok_char(input logic idx);
    logic [7:0] c;
    c = idx ? 8'("K") : 8'("O");
    return c;
  endfunction

endpackage

// File: hw/rtl/at_modem_session_sequencer_unit.sv
// Top level of the AT modem session sequencer: line matchers, session control, output skid.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one transaction per
//   received byte or time tick, each stamped with the current millisecond time.
//   The result channel (out_valid, out_stall, out_data) returns exactly one
//   transaction per input: any command to send, the RPC line flag, the session
//   phase after the item and a notice code.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
//   the retry delay (index 0) and the command timeout (index 1); other indexes
//   are ignored. cfg_ready is always high; write only while the block is idle.
//   A transaction accepted at one edge is shown on the result channel after that edge
//   unless the receiver stalls. Throughput is one transaction per cycle while in_stall
//   is low, set by the single registered pass through the matchers and session logic.
//   When the receiver stalls, one further result is held in a skid register and
//   in_stall then rises until the held results drain.
//   Synchronous reset puts the session in sync with no command outstanding,
//   clears the line matchers, empties both output registers and restores the
//   register defaults (5000 ms retry delay, 10000 ms command timeout).
`timescale 1ns / 1ps

module at_modem_session_sequencer_unit #(
  parameter int unsigned LINE_CAPACITY = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  atms_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output atms_pkg::out_item_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [atms_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [atms_pkg::TIME_W-1:0]          cfg_data
);

  localparam int unsigned LC_W = $clog2(LINE_CAPACITY);
  localparam logic [LC_W-1:0] LINE_LAST = LC_W'(LINE_CAPACITY - 1);

  // Configuration registers.
  logic [atms_pkg::TIME_W-1:0] retry_delay_r;
  logic [atms_pkg::TIME_W-1:0] cmd_timeout_r;

  // Session and matcher state.
  logic [3:0]                  phase_r, phase_nxt;
  logic                        outstanding_r, outstanding_nxt;
  logic [atms_pkg::TIME_W-1:0] start_r, start_nxt;
  logic [LC_W-1:0]             line_count_r, line_count_nxt;
  logic                        ok_match_r, ok_match_nxt;
  logic                        err_match_r, err_match_nxt;
  logic [3:0]                  prefix_prog_r, prefix_prog_nxt;
  logic                        prefix_alive_r, prefix_alive_nxt;
  logic [3:0]                  disc_prog_r, disc_prog_nxt;
  logic                        disc_seen_r, disc_seen_nxt;

  // Output register and skid register.
  logic                        out_valid_r;
  atms_pkg::out_item_t         out_data_r;
  logic                        skid_valid_r;
  atms_pkg::out_item_t         skid_data_r;

  atms_pkg::out_item_t         res;
  logic                        accept;
  logic                        out_free;
  logic [atms_pkg::TIME_W-1:0] elapsed;
  logic                        is_prefix, is_error, is_ok;
  logic [3:0]                  disc_step;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign elapsed   = in_data.now_ms - start_r;
  assign is_prefix = prefix_alive_r && (prefix_prog_r == atms_pkg::PREFIX_LEN);
  assign is_error  = err_match_r && (line_count_r == LC_W'(atms_pkg::ERROR_LEN));
  assign is_ok     = ok_match_r && (line_count_r == LC_W'(atms_pkg::OK_LEN));

  // Disconnect search step; no proper prefix of the word overlaps itself.
  always_comb begin
    if (disc_prog_r < atms_pkg::DISC_LEN &&
        in_data.rx_byte == atms_pkg::disc_char(disc_prog_r)) begin
      disc_step = disc_prog_r + 4'd1;
    end else if (in_data.rx_byte == atms_pkg::disc_char(4'd0)) begin
      disc_step = 4'd1;
    end else begin
      disc_step = 4'd0;
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    outstanding_nxt  = outstanding_r;
    start_nxt        = start_r;
    line_count_nxt   = line_count_r;
    ok_match_nxt     = ok_match_r;
    err_match_nxt    = err_match_r;
    prefix_prog_nxt  = prefix_prog_r;
    prefix_alive_nxt = prefix_alive_r;
    disc_prog_nxt    = disc_prog_r;
    disc_seen_nxt    = disc_seen_r;
    res              = '0;

    // A line ends, a retry is entered or a line is too long: matchers restart.
    if (in_data.operation == atms_pkg::OP_TICK) begin
      if (phase_r == atms_pkg::PH_RETRY) begin
        if (elapsed >= retry_delay_r) begin
          // Retry wait is over: restart at sync and send its command at once.
          phase_nxt        = atms_pkg::PH_SYNC;
          outstanding_nxt  = 1'b1;
          start_nxt        = in_data.now_ms;
          res.send_command = 1'b1;
          res.command_code = atms_pkg::PH_SYNC[2:0];
        end
      end else if (phase_r != atms_pkg::PH_ONLINE) begin
        if (outstanding_r) begin
          if (elapsed > cmd_timeout_r) begin
            phase_nxt        = atms_pkg::PH_RETRY;
            outstanding_nxt  = 1'b0;
            start_nxt        = in_data.now_ms;
            line_count_nxt   = '0;
            ok_match_nxt     = 1'b1;
            err_match_nxt    = 1'b1;
            prefix_prog_nxt  = '0;
            prefix_alive_nxt = 1'b1;
            disc_prog_nxt    = '0;
            disc_seen_nxt    = 1'b0;
            res.notice       = atms_pkg::NOTICE_TIMEOUT;
          end
        end else begin
          outstanding_nxt  = 1'b1;
          start_nxt        = in_data.now_ms;
          res.send_command = 1'b1;
          res.command_code = phase_r[2:0];
        end
      end
    end else if (in_data.rx_byte == atms_pkg::CHAR_CR) begin
      // Carriage returns are dropped.
    end else if (in_data.rx_byte == atms_pkg::CHAR_LF) begin
      if (line_count_r != '0) begin
        line_count_nxt   = '0;
        ok_match_nxt     = 1'b1;
        err_match_nxt    = 1'b1;
        prefix_prog_nxt  = '0;
        prefix_alive_nxt = 1'b1;
        disc_prog_nxt    = '0;
        disc_seen_nxt    = 1'b0;
        if (is_prefix) begin
          res.rpc_line = (phase_r == atms_pkg::PH_ONLINE);
        end else if (is_error || disc_seen_r) begin
          phase_nxt       = atms_pkg::PH_RETRY;
          outstanding_nxt = 1'b0;
          start_nxt       = in_data.now_ms;
          res.notice      = atms_pkg::NOTICE_ERROR;
        end else if (is_ok && outstanding_r) begin
          if (phase_r < atms_pkg::PH_ANNOUNCE) begin
            phase_nxt        = phase_r + 4'd1;
            outstanding_nxt  = 1'b1;
            start_nxt        = in_data.now_ms;
            res.send_command = 1'b1;
            res.command_code = phase_nxt[2:0];
          end else if (phase_r == atms_pkg::PH_ANNOUNCE) begin
            phase_nxt       = atms_pkg::PH_ONLINE;
            outstanding_nxt = 1'b0;
            start_nxt       = in_data.now_ms;
            res.notice      = atms_pkg::NOTICE_ONLINE;
          end
        end
      end
    end else if (line_count_r >= LINE_LAST) begin
      phase_nxt        = atms_pkg::PH_RETRY;
      outstanding_nxt  = 1'b0;
      start_nxt        = in_data.now_ms;
      line_count_nxt   = '0;
      ok_match_nxt     = 1'b1;
      err_match_nxt    = 1'b1;
      prefix_prog_nxt  = '0;
      prefix_alive_nxt = 1'b1;
      disc_prog_nxt    = '0;
      disc_seen_nxt    = 1'b0;
      res.notice       = atms_pkg::NOTICE_TOO_LONG;
    end else begin
      ok_match_nxt  = ok_match_r && (line_count_r < LC_W'(atms_pkg::OK_LEN)) &&
                      (in_data.rx_byte == atms_pkg::ok_char(line_count_r[0]));
      err_match_nxt = err_match_r && (line_count_r < LC_W'(atms_pkg::ERROR_LEN)) &&
                      (in_data.rx_byte == atms_pkg::error_char(line_count_r[2:0]));
      if (prefix_alive_r && prefix_prog_r < atms_pkg::PREFIX_LEN) begin
        if (in_data.rx_byte == atms_pkg::prefix_char(prefix_prog_r)) begin
          prefix_prog_nxt = prefix_prog_r + 4'd1;
        end else begin
          prefix_alive_nxt = 1'b0;
        end
      end
      if (!disc_seen_r) begin
        disc_prog_nxt = disc_step;
        disc_seen_nxt = (disc_step == atms_pkg::DISC_LEN);
      end
      line_count_nxt = line_count_r + LC_W'(1);
    end

    res.session_state = phase_nxt;
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_delay_r  <= atms_pkg::RETRY_DELAY_RESET;
      cmd_timeout_r  <= atms_pkg::CMD_TIMEOUT_RESET;
      phase_r        <= atms_pkg::PH_SYNC;
      outstanding_r  <= 1'b0;
      start_r        <= '0;
      line_count_r   <= '0;
      ok_match_r     <= 1'b1;
      err_match_r    <= 1'b1;
      prefix_prog_r  <= '0;
      prefix_alive_r <= 1'b1;
      disc_prog_r    <= '0;
      disc_seen_r    <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == atms_pkg::CFG_RETRY_DELAY) begin
          retry_delay_r <= cfg_data;
        end else if (cfg_index == atms_pkg::CFG_CMD_TIMEOUT) begin
          cmd_timeout_r <= cfg_data;
        end
      end
      if (accept) begin
        phase_r        <= phase_nxt;
        outstanding_r  <= outstanding_nxt;
        start_r        <= start_nxt;
        line_count_r   <= line_count_nxt;
        ok_match_r     <= ok_match_nxt;
        err_match_r    <= err_match_nxt;
        prefix_prog_r  <= prefix_prog_nxt;
        prefix_alive_r <= prefix_alive_nxt;
        disc_prog_r    <= disc_prog_nxt;
        disc_seen_r    <= disc_seen_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
        end
      end else if (accept) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= res;
      end
    end else if (accept) begin
      skid_data_r <= res;
    end
  end

  // A command is only outstanding in one of the command phases.
  a_outstanding_phase: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r |-> (phase_r <= atms_pkg::PH_ANNOUNCE))
    else $error("command outstanding outside the command phases");

  // The skid register only fills behind a held output transaction.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // A command sent carries the code of the phase that the session is then in.
  a_send_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.send_command) |->
      (out_data_r.session_state <= atms_pkg::PH_ANNOUNCE &&
       out_data_r.command_code == out_data_r.session_state[2:0]))
    else $error("sent command does not match session phase");

  // The online notice comes with the online phase, and RPC lines only while online.
  a_online_notice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.notice == atms_pkg::NOTICE_ONLINE ||
                     out_data_r.rpc_line)) |->
      (out_data_r.session_state == atms_pkg::PH_ONLINE))
    else $error("online notice or RPC line outside online phase");

  // A full disconnect match needs at least the word's length in line characters.
  a_disc_length: assert property (@(posedge clk) disable iff (!rst_n)
    disc_seen_r |-> (line_count_r >= LC_W'(atms_pkg::DISC_LEN)))
    else $error("disconnect seen on a line shorter than the word");

endmodule

// File: sim/tb_at_modem_session_sequencer_unit.sv
// Testbench for the AT modem session sequencer: modem dialogue stimulus checked by a session tracker.
`timescale 1ns / 1ps

module tb_at_modem_session_sequencer_unit;

  localparam int LINE_CAP        = 256;
  localparam int QUIET_LIMIT     = 2000;
  localparam int ITEMS_PER_PHASE = 220;

  // Register indexes that the block has to ignore.
  localparam logic [atms_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [atms_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam string WORD_PREFIX = "+MQTTSUBRECV:";
  localparam string WORD_ERROR  = "ERROR";
  localparam string WORD_OK     = "OK";
  localparam string WORD_DISC   = "DISCONNECTED";

  class session_tracker;
    logic [atms_pkg::TIME_W-1:0] retry_delay;
    logic [atms_pkg::TIME_W-1:0] cmd_timeout;
    logic [3:0]                  phase;
    logic                        cmd_out;
    logic [atms_pkg::TIME_W-1:0] phase_t0;
    int unsigned                 line_len;
    logic                        ok_live;
    logic                        err_live;
    int unsigned                 pfx_pos;
    logic                        pfx_live;
    int unsigned                 disc_pos;
    logic                        disc_seen;
    atms_pkg::out_item_t         report;
    atms_pkg::out_item_t         expected_reports[$];
    int unsigned                 errors;

    function new();
      retry_delay = atms_pkg::RETRY_DELAY_RESET;
      cmd_timeout = atms_pkg::CMD_TIMEOUT_RESET;
      phase = atms_pkg::PH_SYNC;
      cmd_out = 1'b0;
      phase_t0 = '0;
      errors = 0;
      clear_line();
    endfunction

    function void set_reg(logic [atms_pkg::CFG_INDEX_W-1:0] idx,
                          logic [atms_pkg::TIME_W-1:0] val);
      case (idx)
        atms_pkg::CFG_RETRY_DELAY: retry_delay = val;
        atms_pkg::CFG_CMD_TIMEOUT: cmd_timeout = val;
        default: ;
      endcase
    endfunction

    function void clear_line();
      line_len = 0;
      ok_live = 1'b1;
      err_live = 1'b1;
      pfx_pos = 0;
      pfx_live = 1'b1;
      disc_pos = 0;
      disc_seen = 1'b0;
    endfunction

    function void start_retry_wait(logic [atms_pkg::TIME_W-1:0] now);
      phase = atms_pkg::PH_RETRY;
      phase_t0 = now;
      cmd_out = 1'b0;
      clear_line();
    endfunction

    function void issue(logic [atms_pkg::TIME_W-1:0] now);
      cmd_out = 1'b1;
      phase_t0 = now;
      report.send_command = 1'b1;
      report.command_code = phase[2:0];
    endfunction

    function void tick(logic [atms_pkg::TIME_W-1:0] now);
      logic [atms_pkg::TIME_W-1:0] elapsed;
      if (phase == atms_pkg::PH_RETRY) begin
        elapsed = now - phase_t0;
        if (elapsed < retry_delay) return;
        phase = atms_pkg::PH_SYNC;
        cmd_out = 1'b0;
        phase_t0 = now;
      end
      if (phase == atms_pkg::PH_ONLINE) return;
      if (cmd_out) begin
        elapsed = now - phase_t0;
        if (elapsed > cmd_timeout) begin
          start_retry_wait(now);
          report.notice = atms_pkg::NOTICE_TIMEOUT;
        end
        return;
      end
      issue(now);
    endfunction

    function void end_line(logic [atms_pkg::TIME_W-1:0] now);
      logic is_prefix;
      logic is_error;
      logic is_ok;
      is_prefix = pfx_live && pfx_pos == atms_pkg::PREFIX_LEN;
      is_error = err_live && line_len == atms_pkg::ERROR_LEN;
      is_ok = ok_live && line_len == atms_pkg::OK_LEN;
      // A subscription line wins over everything else, even when it cannot be used.
      if (is_prefix) begin
        if (phase == atms_pkg::PH_ONLINE) report.rpc_line = 1'b1;
        return;
      end
      if (is_error || disc_seen) begin
        start_retry_wait(now);
        report.notice = atms_pkg::NOTICE_ERROR;
        return;
      end
      if (is_ok && cmd_out) begin
        if (phase < atms_pkg::PH_ANNOUNCE) begin
          phase++;
          cmd_out = 1'b0;
          issue(now);
        end else if (phase == atms_pkg::PH_ANNOUNCE) begin
          phase = atms_pkg::PH_ONLINE;
          cmd_out = 1'b0;
          phase_t0 = now;
          report.notice = atms_pkg::NOTICE_ONLINE;
        end
      end
    endfunction

    function void take_char(logic [7:0] b);
      int unsigned n;
      n = line_len;
      ok_live = ok_live && n < atms_pkg::OK_LEN && b == WORD_OK[n];
      err_live = err_live && n < atms_pkg::ERROR_LEN && b == WORD_ERROR[n];
      if (pfx_live && pfx_pos < atms_pkg::PREFIX_LEN) begin
        if (b == WORD_PREFIX[pfx_pos]) pfx_pos++;
        else pfx_live = 1'b0;
      end
      // No proper prefix of the disconnect word overlaps itself, so a mismatch restarts from its first letter.
      if (!disc_seen) begin
        if (disc_pos < atms_pkg::DISC_LEN && b == WORD_DISC[disc_pos]) disc_pos++;
        else disc_pos = (b == WORD_DISC[0]) ? 1 : 0;
        if (disc_pos == atms_pkg::DISC_LEN) disc_seen = 1'b1;
      end
      line_len = n + 1;
    endfunction

    function void note_item(atms_pkg::in_item_t it);
      report = '0;
      if (it.operation == atms_pkg::OP_TICK) begin
        tick(it.now_ms);
      end else if (it.rx_byte == atms_pkg::CHAR_CR) begin
        // Carriage returns are dropped.
      end else if (it.rx_byte == atms_pkg::CHAR_LF) begin
        if (line_len != 0) begin
          end_line(it.now_ms);
          clear_line();
        end
      end else if (line_len + 1 >= LINE_CAP) begin
        start_retry_wait(it.now_ms);
        report.notice = atms_pkg::NOTICE_TOO_LONG;
      end else begin
        take_char(it.rx_byte);
      end
      report.session_state = phase;
      expected_reports.push_back(report);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_report(atms_pkg::out_item_t got);
      atms_pkg::out_item_t want;
      if (expected_reports.size() == 0) begin
        $error("result %h arrived with no transaction outstanding", got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      compare_field("send_command", want.send_command, got.send_command);
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("rpc_line", want.rpc_line, got.rpc_line);
      compare_field("session_state", want.session_state, got.session_state);
      compare_field("notice", want.notice, got.notice);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  atms_pkg::in_item_t               in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  atms_pkg::out_item_t              out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [atms_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [atms_pkg::TIME_W-1:0]      cfg_data = '0;

  session_tracker              trk;
  bit                          calm = 1'b0;
  logic [atms_pkg::TIME_W-1:0] clock_ms = '0;
  int unsigned                 items_sent = 0;
  int unsigned                 quiet_cycles = 0;

  always #5 clk = ~clk;

  at_modem_session_sequencer_unit #(
    .LINE_CAPACITY(LINE_CAP)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) trk.check_report(out_data);
    out_stall <= !calm && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL at_modem_session_sequencer_unit");
      $finish;
    end
  end

  task automatic drive_item(input atms_pkg::in_item_t it);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    trk.note_item(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    atms_pkg::in_item_t it;
    clock_ms += $urandom_range(0, 3);
    it.operation = atms_pkg::OP_BYTE;
    it.rx_byte = b;
    it.now_ms = clock_ms;
    drive_item(it);
  endtask

  task automatic tick_at(input logic [atms_pkg::TIME_W-1:0] t);
    atms_pkg::in_item_t it;
    clock_ms = t;
    it.operation = atms_pkg::OP_TICK;
    it.rx_byte = 8'($urandom());
    it.now_ms = t;
    drive_item(it);
  endtask

  task automatic tick_step();
    if ($urandom_range(0, 9) == 0) tick_at($urandom());
    else tick_at(clock_ms + $urandom_range(0, 400));
  endtask

  // Lands one below, on, or one past the given span from the start of the phase.
  task automatic tick_near(input logic [atms_pkg::TIME_W-1:0] span);
    tick_at(trk.phase_t0 + span + 32'($urandom_range(0, 2)) - 32'd1);
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_chars(s);
    if ($urandom_range(0, 3) != 0) send_byte(atms_pkg::CHAR_CR);
    send_byte(atms_pkg::CHAR_LF);
  endtask

  function automatic string filler(input int unsigned n);
    string s;
    s = "";
    for (int unsigned i = 0; i < n; i++) s = {s, $sformatf("%c", 8'($urandom_range(97, 122)))};
    return s;
  endfunction

  function automatic string broken_word();
    case ($urandom_range(0, 8))
      0: return "O";
      1: return "OKK";
      2: return "OK ";
      3: return "ERRO";
      4: return "ERRORR";
      5: return "DISCONNECTE";
      6: return "+MQTTSUBRECV";
      7: return "+MQTTSUBRECX:";
      default: return "DISCDISCONNECTED";
    endcase
  endfunction

  task automatic overlong_line();
    int unsigned n;
    n = $urandom_range(LINE_CAP - 3, LINE_CAP + 2);
    repeat (n) send_byte(8'($urandom_range(97, 122)));
    send_byte(atms_pkg::CHAR_LF);
  endtask

  task automatic noise_move();
    case ($urandom_range(0, 5))
      0: repeat ($urandom_range(1, 8)) send_byte(8'($urandom()));
      1: send_line(broken_word());
      2: send_byte($urandom_range(0, 1) ? atms_pkg::CHAR_CR : atms_pkg::CHAR_LF);
      3: begin
        if ($urandom_range(0, 24) == 0) overlong_line();
        else send_line(filler($urandom_range(0, 10)));
      end
      4: tick_step();
      default: send_line(WORD_OK);
    endcase
  endtask

  task automatic online_move();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) send_line({WORD_PREFIX, filler($urandom_range(0, 6))});
    else if (r < 50) send_line({"+MQTTSUBRECV", filler(2)});
    else if (r < 60) send_line({filler($urandom_range(0, 3)), WORD_DISC, filler($urandom_range(0, 2))});
    else if (r < 65) send_line({WORD_PREFIX, WORD_DISC});
    else if (r < 72) send_line(WORD_OK);
    else if (r < 77) send_line(WORD_ERROR);
    else if (r < 90) tick_step();
    else send_line(filler($urandom_range(1, 8)));
  endtask

  // Mostly a well-behaved modem answering each command, with faults mixed in.
  task automatic session_move();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) noise_move();
    else if (trk.phase == atms_pkg::PH_RETRY) begin
      if (r < 55) tick_near(trk.retry_delay);
      else tick_step();
    end else if (trk.phase == atms_pkg::PH_ONLINE) online_move();
    else if (!trk.cmd_out) tick_step();
    else if (r < 70) send_line(WORD_OK);
    else if (r < 75) send_line(WORD_ERROR);
    else if (r < 81) tick_near(trk.cmd_timeout);
    else if (r < 90) tick_step();
    else if (r < 95) send_line({WORD_PREFIX, filler(3)});
    else send_line(filler($urandom_range(1, 6)));
  endtask

  task automatic write_reg(input logic [atms_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [atms_pkg::TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk.set_reg(idx, val);
  endtask

  task automatic run_phase(input logic [atms_pkg::TIME_W-1:0] delay,
                           input logic [atms_pkg::TIME_W-1:0] cmd_wait);
    int unsigned goal;
    in_valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    write_reg(atms_pkg::CFG_RETRY_DELAY, delay);
    write_reg(atms_pkg::CFG_CMD_TIMEOUT, cmd_wait);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
    cfg_valid <= 1'b0;
    goal = items_sent + ITEMS_PER_PHASE;
    while (items_sent < goal) session_move();
  endtask

  initial begin
    trk = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Short directed session on the reset settings.
    tick_at(32'd0);
    send_byte(atms_pkg::CHAR_CR);
    send_byte(atms_pkg::CHAR_LF);
    send_chars(WORD_OK);
    send_byte(atms_pkg::CHAR_LF);
    send_byte(8'h00);
    send_byte(atms_pkg::CHAR_LF);
    tick_at(trk.phase_t0 + trk.cmd_timeout);
    tick_at(trk.phase_t0 + trk.cmd_timeout + 1);
    send_chars(WORD_OK);
    send_byte(atms_pkg::CHAR_LF);
    tick_at(trk.phase_t0 + trk.retry_delay - 1);
    tick_at(trk.phase_t0 + trk.retry_delay);
    send_chars(WORD_ERROR);
    send_byte(atms_pkg::CHAR_LF);
    tick_at(32'hFFFF_FFFF);

    run_phase(32'd0, 32'd0);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // No idling on either side here, and time runs across the wrap.
    calm = 1'b1;
    clock_ms = 32'hFFFF_FC00;
    run_phase($urandom_range(1, 3000), $urandom_range(1, 3000));
    overlong_line();
    calm = 1'b0;
    run_phase($urandom(), $urandom());
    run_phase(32'd0, 32'hFFFF_FFFF);
    run_phase(32'hFFFF_FFFF, 32'd0);
    run_phase(atms_pkg::RETRY_DELAY_RESET, atms_pkg::CMD_TIMEOUT_RESET);

    in_valid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (trk.errors == 0) begin
      $display("PASS at_modem_session_sequencer_unit");
    end else begin
      $display("FAIL at_modem_session_sequencer_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/atms_pkg.sv
hw/rtl/at_modem_session_sequencer_unit.sv
sim/tb_at_modem_session_sequencer_unit.sv
